FILE: rtl/core/htw_pkg.sv
`timescale 1ns / 1ps
// Shared codes and constants of the hashed timer wheel.
package htw_pkg;

  typedef enum logic [1:0] {
    ACT_ARM     = 2'd0,
    ACT_DISARM  = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  localparam int DividendW = 33;
  localparam int DivSteps  = 33;
  localparam int ResW      = 16;
  localparam int IdW       = 6;
  localparam int CountW    = 7;

endpackage

FILE: rtl/core/htw_ram.sv
`timescale 1ns / 1ps
// Generic RAM, one write port, one read port with registered read data.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/hashed_timer_wheel.sv
`timescale 1ns / 1ps
// Hashed timer wheel: slot heads, linked timer lists and expiry times in RAM.
// Disarm unlinks an armed timer; arm runs a 33-step serial divide for the slot,
// then unlinks (if armed) and links through the link RAMs; one item at a time.
// Advance walks the slots, visits each timer and expires the due ones; it can stall on the
// result port. Configuration writes: any time.
// After reset a pass over all SLOT_COUNT slots clears the slot heads; no word is taken before.
module hashed_timer_wheel
  import htw_pkg::*;
#(
  parameter int SLOT_COUNT  = 1024,
  parameter int TIMER_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ResW-1:0]   cfg_resolution_ms_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [IdW-1:0]    timer_id_i,
  input  logic [30:0]       duration_ms_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              expired_valid_o,
  output logic [IdW-1:0]    expired_id_o,
  output logic              last_o,
  output logic [CountW-1:0] active_count_o,
  output logic              wheel_empty_o
);

  localparam int SlotW = $clog2(SLOT_COUNT);
  localparam int TidW  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int LinkW = TidW + 1;
  localparam int LW    = (SlotW > TidW) ? SlotW : TidW;
  localparam int PrevW = LW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PREP, S_DIVI, S_DIV, S_DISP, S_URD, S_UWR, S_LRD, S_LWR,
    S_LWR2, S_EMIT, S_ASLOT, S_AHEAD, S_AWALK, S_ARD, S_ACHK, S_AEXP, S_AEND
  } state_e;

  state_e              state_q;
  logic [ResW-1:0]     res_q;
  logic [1:0]          act_q;
  logic [TidW-1:0]     t_q;
  logic [30:0]         dur_q;
  logic [31:0]         now_q;
  logic [31:0]         key_q;
  logic [DividendW-1:0] dvd_q;
  logic [ResW-1:0]     rem_q;
  logic [SlotW-1:0]    qmod_q;
  logic [5:0]          cnt_q;
  logic [SlotW-1:0]    slot_q;
  logic [SlotW-1:0]    cur_q;
  logic [SlotW-1:0]    clr_q;
  logic [LinkW-1:0]    h_q;
  logic [LinkW-1:0]    n_q;
  logic                pend_v_q;
  logic [TidW-1:0]     pend_id_q;
  logic [CountW-1:0]   pend_cnt_q;
  logic [TIMER_COUNT-1:0] armed_q;
  logic [CountW-1:0]   total_q;
  logic                out_valid_q;
  logic                out_exp_q;
  logic [IdW-1:0]      out_id_q;
  logic                out_last_q;
  logic [CountW-1:0]   out_cnt_q;

  logic                head_we, next_we, prev_we, exp_we;
  logic [SlotW-1:0]    head_waddr, head_raddr;
  logic [LinkW-1:0]    head_wdata, head_rdata;
  logic [TidW-1:0]     next_waddr, prev_waddr;
  logic [LinkW-1:0]    next_wdata, next_rdata;
  logic [PrevW-1:0]    prev_wdata, prev_rdata, prev_head;
  logic [31:0]         exp_rdata;

  logic                id_ok;
  logic [TidW-1:0]     in_tid;
  logic [ResW:0]       rem2;
  logic                ge;
  logic [SlotW:0]      qt;
  logic [30:0]         dur_m;
  logic [31:0]         diff;
  logic                out_free;
  logic                out_load;

  assign id_ok    = {1'b0, timer_id_i} < CountW'(TIMER_COUNT);
  assign in_tid   = timer_id_i[TidW-1:0];
  assign rem2     = {rem_q, dvd_q[DividendW-1]};
  assign ge       = rem2 >= {1'b0, res_q};
  assign qt       = {qmod_q, ge};
  assign dur_m    = (dur_q < 31'(res_q)) ? 31'(res_q) : dur_q;
  assign diff     = key_q - exp_rdata;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_AEND) ||
                                 (state_q == S_AEXP && pend_v_q));

  always_comb begin
    prev_head = '0;
    prev_head[LW] = 1'b1;
    prev_head[SlotW-1:0] = slot_q;
  end

  always_comb begin
    head_raddr = (state_q == S_LRD) ? slot_q : cur_q;
    head_we    = 1'b0;
    head_waddr = clr_q;
    head_wdata = '0;
    next_we    = 1'b0;
    next_waddr = t_q;
    next_wdata = head_rdata;
    prev_we    = 1'b0;
    prev_waddr = t_q;
    prev_wdata = prev_head;
    exp_we     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        head_we = 1'b1;
      end
      S_LWR: begin
        head_we    = 1'b1;
        head_waddr = slot_q;
        head_wdata = {1'b1, t_q};
        next_we    = 1'b1;
        prev_we    = 1'b1;
        exp_we     = 1'b1;
      end
      S_LWR2: begin
        prev_we    = 1'b1;
        prev_waddr = n_q[TidW-1:0];
        prev_wdata = '0;
        prev_wdata[TidW-1:0] = t_q;
      end
      S_UWR: begin
        if (prev_rdata[LW]) begin
          head_we    = 1'b1;
          head_waddr = prev_rdata[SlotW-1:0];
          head_wdata = next_rdata;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[TidW-1:0];
          next_wdata = next_rdata;
        end
        prev_we    = next_rdata[TidW];
        prev_waddr = next_rdata[TidW-1:0];
        prev_wdata = prev_rdata;
      end
      default: begin
      end
    endcase
  end

  htw_ram #(.WIDTH(LinkW), .DEPTH(SLOT_COUNT)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  htw_ram #(.WIDTH(LinkW), .DEPTH(TIMER_COUNT)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(t_q), .rdata_o(next_rdata)
  );
  htw_ram #(.WIDTH(PrevW), .DEPTH(TIMER_COUNT)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(t_q), .rdata_o(prev_rdata)
  );
  htw_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(t_q), .wdata_i(key_q),
    .raddr_i(t_q), .rdata_o(exp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_q       <= ResW'(1);
      clr_q       <= '0;
      cur_q       <= '0;
      armed_q     <= '0;
      total_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      act_q       <= ACT_NONE;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        res_q <= (cfg_resolution_ms_i == '0) ? ResW'(1) : cfg_resolution_ms_i;
      end
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SlotW'(1);
          if (clr_q == SlotW'(SLOT_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            act_q <= action_i;
            t_q   <= in_tid;
            dur_q <= duration_ms_i;
            now_q <= now_ms_i;
            case (action_i)
              ACT_ARM:     state_q <= id_ok ? S_PREP : S_EMIT;
              ACT_DISARM:  state_q <= (id_ok && armed_q[in_tid]) ? S_URD : S_EMIT;
              ACT_ADVANCE: state_q <= S_PREP;
              default:     state_q <= S_EMIT;
            endcase
          end
        end
        S_PREP: begin
          key_q   <= (act_q == ACT_ARM) ? now_q + 32'(dur_m) : now_q + 32'(res_q);
          state_q <= S_DIVI;
        end
        S_DIVI: begin
          dvd_q   <= {1'b0, key_q} + DividendW'(res_q) - DividendW'(1);
          rem_q   <= '0;
          qmod_q  <= '0;
          cnt_q   <= 6'(DivSteps);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= ge ? ResW'(rem2 - {1'b0, res_q}) : rem2[ResW-1:0];
          qmod_q <= (qt >= (SlotW + 1)'(SLOT_COUNT)) ?
                    SlotW'(qt - (SlotW + 1)'(SLOT_COUNT)) : qt[SlotW-1:0];
          dvd_q  <= dvd_q << 1;
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          slot_q <= qmod_q;
          if (act_q == ACT_ARM) begin
            state_q <= armed_q[t_q] ? S_URD : S_LRD;
          end else begin
            pend_v_q <= 1'b0;
            state_q  <= S_ASLOT;
          end
        end
        S_URD: begin
          state_q <= S_UWR;
        end
        S_UWR: begin
          armed_q[t_q] <= 1'b0;
          total_q      <= total_q - CountW'(1);
          case (act_q)
            ACT_ARM:    state_q <= S_LRD;
            ACT_DISARM: state_q <= S_EMIT;
            default:    state_q <= S_AEXP;
          endcase
        end
        S_LRD: begin
          state_q <= S_LWR;
        end
        S_LWR: begin
          n_q          <= head_rdata;
          armed_q[t_q] <= 1'b1;
          total_q      <= total_q + CountW'(1);
          state_q      <= head_rdata[TidW] ? S_LWR2 : S_EMIT;
        end
        S_LWR2: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_exp_q   <= 1'b0;
            out_id_q    <= '0;
            out_last_q  <= 1'b1;
            out_cnt_q   <= total_q;
            state_q     <= S_IDLE;
          end
        end
        S_ASLOT: begin
          state_q <= (cur_q == slot_q) ? S_AEND : S_AHEAD;
        end
        S_AHEAD: begin
          h_q     <= head_rdata;
          state_q <= S_AWALK;
        end
        S_AWALK: begin
          if (h_q[TidW]) begin
            t_q     <= h_q[TidW-1:0];
            state_q <= S_ARD;
          end else begin
            cur_q   <= (cur_q == SlotW'(SLOT_COUNT - 1)) ? '0 : cur_q + SlotW'(1);
            state_q <= S_ASLOT;
          end
        end
        S_ARD: begin
          state_q <= S_ACHK;
        end
        S_ACHK: begin
          n_q <= next_rdata;
          h_q <= next_rdata;
          state_q <= diff[31] ? S_AWALK : S_URD;
        end
        S_AEXP: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_q <= 1'b1;
              out_exp_q   <= 1'b1;
              out_id_q    <= IdW'(pend_id_q);
              out_last_q  <= 1'b0;
              out_cnt_q   <= pend_cnt_q;
            end
            pend_v_q   <= 1'b1;
            pend_id_q  <= t_q;
            pend_cnt_q <= total_q;
            h_q        <= n_q;
            state_q    <= S_AWALK;
          end
        end
        S_AEND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_exp_q   <= pend_v_q;
            out_id_q    <= pend_v_q ? IdW'(pend_id_q) : '0;
            out_last_q  <= 1'b1;
            out_cnt_q   <= pend_v_q ? pend_cnt_q : total_q;
            pend_v_q    <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign expired_valid_o = out_exp_q;
  assign expired_id_o    = out_id_q;
  assign last_o          = out_last_q;
  assign active_count_o  = out_cnt_q;
  assign wheel_empty_o   = (out_cnt_q == '0);

endmodule

FILE: rtl/core/htw_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the timer wheel result channel, bound to the top level.
module htw_sva
  import htw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              expired_valid_o,
  input logic [IdW-1:0]    expired_id_o,
  input logic              last_o,
  input logic [CountW-1:0] active_count_o,
  input logic              wheel_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(active_count_o))
    else $error("result word dropped while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wheel_empty_o == (active_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> active_count_o <= CountW'(64))
    else $error("count out of range");

  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !expired_valid_o |-> last_o && expired_id_o == '0)
    else $error("non-expiry word must be last with id zero");

endmodule

bind hashed_timer_wheel htw_sva u_htw_sva (.*);

FILE: tb/htw_checker.sv
`timescale 1ns / 1ps
// Checker for the hashed timer wheel: tracks the wheel, predicts each result word and compares.
module htw_checker
  import htw_pkg::*;
#(
  parameter int SLOTS  = 1024,
  parameter int TIMERS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [ResW-1:0]   cfg_resolution_ms_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        action_i,
  input  logic [IdW-1:0]    timer_id_i,
  input  logic [30:0]       duration_ms_i,
  input  logic [31:0]       now_ms_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              expired_valid_i,
  input  logic [IdW-1:0]    expired_id_i,
  input  logic              last_i,
  input  logic [CountW-1:0] active_count_i,
  input  logic              wheel_empty_i,
  output int                errors_o,
  output int                pending_o
);

  localparam logic [7:0]  NoTimer  = 8'hFF;
  localparam logic [31:0] HeadFlag = 32'h0001_0000;

  typedef struct packed {
    logic              fired;
    logic [IdW-1:0]    id;
    logic              last;
    logic [CountW-1:0] count;
    logic              empty;
  } wheel_result_t;

  wheel_result_t expected_results[$];

  logic [7:0]  slot_head [SLOTS];
  logic [7:0]  next_id   [TIMERS];
  logic [31:0] prev_ref  [TIMERS];
  logic [31:0] expiry    [TIMERS];
  logic        armed     [TIMERS];
  int unsigned cur_slot;
  int unsigned armed_cnt;
  logic [15:0] res_ms;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_results.size();

  function automatic int unsigned slot_for(logic [31:0] key);
    logic [63:0] q;
    q = ({32'd0, key} + 64'(res_ms) - 64'd1) / 64'(res_ms);
    return int'(q % 64'(SLOTS));
  endfunction

  function automatic wheel_result_t make_result(logic fired, int unsigned id, logic last);
    wheel_result_t r;
    r.fired = fired;
    r.id    = IdW'(id);
    r.last  = last;
    r.count = CountW'(armed_cnt);
    r.empty = (armed_cnt == 0);
    return r;
  endfunction

  task automatic unlink(int unsigned id);
    logic [31:0] p;
    logic [7:0]  n;
    p = prev_ref[id];
    n = next_id[id];
    if (p & HeadFlag) begin
      slot_head[(p & 32'hFFFF) % SLOTS] = n;
    end else if (p < TIMERS) begin
      next_id[p] = n;
    end
    if (n < TIMERS) prev_ref[n] = p;
  endtask

  task automatic link(int unsigned id, int unsigned s);
    logic [7:0] n;
    n = slot_head[s];
    next_id[id]  = n;
    prev_ref[id] = HeadFlag | s;
    slot_head[s] = 8'(id);
    if (n < TIMERS) prev_ref[n] = id;
  endtask

  task automatic predict_word(action_e act, int unsigned id, logic [30:0] dur,
                              logic [31:0] now);
    logic [31:0] span;
    logic [31:0] key;
    logic [31:0] horizon;
    logic [31:0] diff;
    int unsigned target;
    int unsigned t;
    logic [7:0]  h;
    int          k;
    wheel_result_t r;
    case (act)
      ACT_ARM: begin
        if (armed[id]) begin
          unlink(id);
          armed[id] = 1'b0;
          armed_cnt--;
        end
        span = {1'b0, dur};
        if (span < res_ms) span = res_ms;
        key = now + span;
        expiry[id] = key;
        link(id, slot_for(key));
        armed[id] = 1'b1;
        armed_cnt++;
        expected_results.push_back(make_result(1'b0, 0, 1'b1));
      end
      ACT_DISARM: begin
        if (armed[id]) begin
          unlink(id);
          armed[id] = 1'b0;
          armed_cnt--;
        end
        expected_results.push_back(make_result(1'b0, 0, 1'b1));
      end
      ACT_ADVANCE: begin
        horizon = now + res_ms;
        target  = slot_for(horizon);
        k = 0;
        while (cur_slot != target) begin
          h = slot_head[cur_slot];
          while (h < TIMERS) begin
            t = h;
            diff = horizon - expiry[t];
            h = next_id[t];
            if (!diff[31]) begin
              unlink(t);
              armed[t] = 1'b0;
              armed_cnt--;
              expected_results.push_back(make_result(1'b1, t, 1'b0));
              k++;
            end
          end
          cur_slot = (cur_slot + 1) % SLOTS;
        end
        if (k == 0) begin
          expected_results.push_back(make_result(1'b0, 0, 1'b1));
        end else begin
          r = expected_results.pop_back();
          r.last = 1'b1;
          expected_results.push_back(r);
        end
      end
      default: begin
        expected_results.push_back(make_result(1'b0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_word(wheel_result_t got);
    wheel_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word %p", $time, got);
      return;
    end
    want = expected_results.pop_front();
    if (want != got) begin
      errors++;
      $display("%0t: result mismatch expected %p actual %p", $time, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_head[i] = NoTimer;
      for (int i = 0; i < TIMERS; i++) begin
        next_id[i]  = '0;
        prev_ref[i] = '0;
        expiry[i]   = '0;
        armed[i]    = 1'b0;
      end
      cur_slot  = 0;
      armed_cnt = 0;
      res_ms    = 16'd1;
      errors    = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        res_ms = (cfg_resolution_ms_i == 0) ? 16'd1 : cfg_resolution_ms_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_word(action_e'(action_i), timer_id_i, duration_ms_i, now_ms_i);
      end
      if (out_valid_i && out_ready_i) begin
        compare_word({expired_valid_i, expired_id_i, last_i, active_count_i, wheel_empty_i});
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the hashed timer wheel: stimulus, idling, watchdog and verdict.
module tb;
  import htw_pkg::*;

  localparam int StallLimit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ResW-1:0]   cfg_resolution_ms_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i = '0;
  logic [IdW-1:0]    timer_id_i = '0;
  logic [30:0]       duration_ms_i = '0;
  logic [31:0]       now_ms_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              expired_valid_o;
  logic [IdW-1:0]    expired_id_o;
  logic              last_o;
  logic [CountW-1:0] active_count_o;
  logic              wheel_empty_o;

  int          errors;
  int          pending;
  int          tx_idle_pct = 17;
  int          rx_idle_pct = 53;
  bit          hold_rx = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms = 0;
  logic [15:0] res_now = 16'd1;

  always #5 clk_i = ~clk_i;

  hashed_timer_wheel u_top (.*);

  htw_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_resolution_ms_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .timer_id_i, .duration_ms_i, .now_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i, .expired_valid_i(expired_valid_o),
    .expired_id_i(expired_id_o), .last_i(last_o), .active_count_i(active_count_o),
    .wheel_empty_i(wheel_empty_o), .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (hold_rx) begin
      out_ready_i <= 1'b0;
      repeat (400) @(negedge clk_i);
      hold_rx = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(action_e act, int unsigned id, logic [30:0] dur, logic [31:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    timer_id_i    <= IdW'(id);
    duration_ms_i <= dur;
    now_ms_i      <= now;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_resolution(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_resolution_ms_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    res_now = (value == 0) ? 16'd1 : value;
  endtask

  task automatic random_words(int count);
    int          pick;
    logic [30:0] dur;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) dur = 31'($urandom);
        else dur = 31'($urandom_range(0, 32'(res_now) * 8));
        send_word(ACT_ARM, $urandom_range(63), dur, clock_ms);
      end else if (pick < 65) begin
        send_word(ACT_DISARM, $urandom_range(63), 31'($urandom), clock_ms);
      end else if (pick < 95) begin
        if ($urandom_range(19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 32'(res_now) * 6);
        send_word(ACT_ADVANCE, $urandom_range(63), 31'($urandom), clock_ms);
      end else begin
        send_word(ACT_NONE, $urandom_range(63), 31'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_resolution(16'd0);
    send_word(ACT_ARM, 0, 31'd0, 32'd0);
    send_word(ACT_ARM, 63, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_DISARM, 5, 31'd0, 32'd0);
    send_word(ACT_NONE, 7, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_ARM, 1, 31'd5, 32'd10);
    send_word(ACT_ARM, 1, 31'd3, 32'd10);
    send_word(ACT_ARM, 2, 31'd3, 32'd10);
    send_word(ACT_ARM, 3, 31'd900, 32'd10);
    send_word(ACT_ADVANCE, 0, 31'd0, 32'd20);
    send_word(ACT_ADVANCE, 0, 31'd0, 32'd20);
    send_word(ACT_DISARM, 63, 31'd0, 32'd0);
    send_word(ACT_DISARM, 63, 31'd0, 32'd0);
    for (int i = 0; i < 6; i++) send_word(ACT_ARM, 10 + i, 31'(i * 2), 32'd30);
    send_word(ACT_ADVANCE, 0, 31'd0, 32'd1000);
    send_word(ACT_ADVANCE, 0, 31'd0, 32'd900);
    drain();
    set_resolution(16'hFFFF);
    send_word(ACT_ARM, 4, 31'd70000, 32'd0);
    send_word(ACT_ARM, 5, 31'd1, 32'hFFFF_0000);
    send_word(ACT_ADVANCE, 0, 31'd0, 32'd200000);
    drain();
    clock_ms = 200000;

    set_resolution(16'd1);
    random_words(120);
    drain();

    tx_idle_pct = 53;
    rx_idle_pct = 17;
    set_resolution(16'hFFFF);
    random_words(120);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_resolution(16'($urandom_range(2, 200)));
    random_words(20);
    hold_rx = 1'b1;
    random_words(100);
    drain();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/htw_pkg.sv
rtl/core/htw_ram.sv
rtl/core/hashed_timer_wheel.sv
rtl/core/htw_checker.sv
tb/htw_checker.sv
tb/tb.sv
